@@ rtl/crm_pkg.sv @@
// ----------------------------------------------------------------------------
// crm_pkg
// Shared widths, operation codes, flag struct and kind decoding for the
// CIGAR reference-to-read mapper.
// ----------------------------------------------------------------------------
package crm_pkg;

  // Fixed widths of the channel fields
  localparam int LEN_W  = 28;
  localparam int KIND_W = 4;
  localparam int POS_W  = 31;

  // CIGAR operation codes
  localparam logic [KIND_W-1:0] KIND_M  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_I  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_D  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_N  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_S  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_H  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_P  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_EQ = 4'd7;
  localparam logic [KIND_W-1:0] KIND_X  = 4'd8;

  // Record flags carried between the state registers and the step logic
  typedef struct packed {
    logic answer_fixed;
    logic overflow_seen;
  } crm_flags_t;

  // How one operation moves the offsets
  typedef struct packed {
    logic is_match;
    logic adv_ref;
    logic adv_read;
  } crm_move_t;

  function automatic crm_move_t decode_kind(input logic [KIND_W-1:0] kind);
    crm_move_t mv;
    mv = '0;
    unique case (kind)
      KIND_M, KIND_EQ, KIND_X: begin
        mv.is_match = 1'b1;
        mv.adv_ref  = 1'b1;
        mv.adv_read = 1'b1;
      end
      KIND_D, KIND_N: mv.adv_ref = 1'b1;
      KIND_I, KIND_S: mv.adv_read = 1'b1;
      // H, P and unused codes move neither offset
      default: mv = '0;
    endcase
    return mv;
  endfunction

endpackage

@@ rtl/crm_if.sv @@
// ----------------------------------------------------------------------------
// crm_if
// Valid/ready channels of the mapper: operation items in, results out.
// ----------------------------------------------------------------------------
interface crm_in_if;
  logic                        valid;
  logic                        ready;
  logic [crm_pkg::LEN_W-1:0]   op_length;
  logic [crm_pkg::KIND_W-1:0]  op_kind;
  logic                        first_op;
  logic                        last_op;
  logic [crm_pkg::POS_W-1:0]   read_start;
  logic [crm_pkg::POS_W-1:0]   query_pos;

  modport source (
    output valid, op_length, op_kind, first_op, last_op, read_start, query_pos,
    input  ready
  );
  modport sink (
    input  valid, op_length, op_kind, first_op, last_op, read_start, query_pos,
    output ready
  );
endinterface

interface crm_out_if;
  logic                        valid;
  logic                        ready;
  logic [crm_pkg::POS_W-1:0]   ref_end;
  logic [crm_pkg::POS_W-1:0]   read_offset;
  logic                        saturated;

  modport source (output valid, ref_end, read_offset, saturated, input ready);
  modport sink   (input valid, ref_end, read_offset, saturated, output ready);
endinterface

@@ rtl/crm_step.sv @@
// ----------------------------------------------------------------------------
// crm_step
// Next-state and result logic for one CIGAR operation: saturating offset
// sums, query crossing detection and read offset extrapolation.
// ----------------------------------------------------------------------------
module crm_step #(
  parameter int POS_BITS = 31
) (
  // operation
  input  logic [crm_pkg::LEN_W-1:0]  op_length,
  input  logic [crm_pkg::KIND_W-1:0] op_kind,
  input  logic                       first_op,
  input  logic                       last_op,
  input  logic [crm_pkg::POS_W-1:0]  read_start,
  input  logic [crm_pkg::POS_W-1:0]  query_pos,
  // current state
  input  logic [POS_BITS-1:0]        ref_cur,
  input  logic [POS_BITS-1:0]        read_cur,
  input  logic [POS_BITS-1:0]        prior_ref,
  input  logic [POS_BITS-1:0]        prior_read,
  input  logic [POS_BITS-1:0]        end_sum,
  input  logic [POS_BITS-1:0]        query_hold,
  input  logic [POS_BITS-1:0]        answer_hold,
  input  crm_pkg::crm_flags_t        flags,
  // next state
  output logic [POS_BITS-1:0]        ref_cur_nxt,
  output logic [POS_BITS-1:0]        read_cur_nxt,
  output logic [POS_BITS-1:0]        prior_ref_nxt,
  output logic [POS_BITS-1:0]        prior_read_nxt,
  output logic [POS_BITS-1:0]        end_sum_nxt,
  output logic [POS_BITS-1:0]        query_hold_nxt,
  output logic [POS_BITS-1:0]        answer_hold_nxt,
  output crm_pkg::crm_flags_t        flags_nxt,
  // result fields
  output logic [crm_pkg::POS_W-1:0]  res_ref_end,
  output logic [crm_pkg::POS_W-1:0]  res_read_offset,
  output logic                       res_saturated
);

  // addend width covers both op lengths and position differences
  localparam int ADD_W = (POS_BITS > crm_pkg::LEN_W) ? POS_BITS : crm_pkg::LEN_W;
  localparam int SUM_W = ADD_W + 1;
  // width at which a raw input position is compared against the limit
  localparam int CLP_W = (POS_BITS > crm_pkg::POS_W) ? POS_BITS : crm_pkg::POS_W;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  // Clamp an input position to the positive limit
  function automatic logic [POS_BITS-1:0] clamp_pos(input logic [crm_pkg::POS_W-1:0] x);
    logic [CLP_W-1:0] xw;
    xw = CLP_W'(x);
    if (xw > CLP_W'(POS_MAX)) return POS_MAX;
    return xw[POS_BITS-1:0];
  endfunction

  // Saturating add: top bit flags that the sum reached the limit
  function automatic logic [POS_BITS:0] sat_add(input logic [POS_BITS-1:0] a,
                                                input logic [ADD_W-1:0]    b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s >= SUM_W'(POS_MAX)) return {1'b1, POS_MAX};
    return {1'b0, s[POS_BITS-1:0]};
  endfunction

  // Read offset extrapolated from the last position at or before the query
  function automatic logic [POS_BITS:0] extrapolate(input logic [POS_BITS-1:0] q,
                                                    input logic [POS_BITS-1:0] pr,
                                                    input logic [POS_BITS-1:0] prd);
    logic [POS_BITS-1:0] d;
    d = (q >= pr) ? (q - pr) : '0;
    return sat_add(prd, ADD_W'(d));
  endfunction

  crm_pkg::crm_move_t  mv;
  logic [POS_BITS-1:0] start_c;
  logic [POS_BITS-1:0] query_c;
  logic [ADD_W-1:0]    len_w;
  logic                ovf_end;
  logic                ovf_ref;
  logic                ovf_read;
  logic                ovf_cross;
  logic                ovf_last;

  assign mv      = crm_pkg::decode_kind(op_kind);
  assign start_c = clamp_pos(read_start);
  assign query_c = clamp_pos(query_pos);
  assign len_w   = ADD_W'(op_length);

  // Walk the operation through the record state
  always_comb begin
    ref_cur_nxt     = ref_cur;
    read_cur_nxt    = read_cur;
    prior_ref_nxt   = prior_ref;
    prior_read_nxt  = prior_read;
    end_sum_nxt     = end_sum;
    query_hold_nxt  = query_hold;
    answer_hold_nxt = answer_hold;
    flags_nxt       = flags;
    ovf_end         = 1'b0;
    ovf_ref         = 1'b0;
    ovf_read        = 1'b0;
    ovf_cross       = 1'b0;
    ovf_last        = 1'b0;

    // load a new record
    if (first_op) begin
      query_hold_nxt          = query_c;
      ref_cur_nxt             = start_c;
      prior_ref_nxt           = start_c;
      end_sum_nxt             = start_c;
      read_cur_nxt            = '0;
      prior_read_nxt          = '0;
      flags_nxt.overflow_seen = 1'b0;
      flags_nxt.answer_fixed  = start_c > query_c;
      answer_hold_nxt         = '0;
    end

    // reference end keeps counting after the answer is settled
    if (mv.adv_ref) begin
      {ovf_end, end_sum_nxt} = sat_add(end_sum_nxt, len_w);
    end

    // advance cursors until the query is passed
    if (!flags_nxt.answer_fixed) begin
      if (mv.adv_ref) begin
        {ovf_ref, ref_cur_nxt} = sat_add(ref_cur_nxt, len_w);
      end
      if (mv.adv_read) begin
        {ovf_read, read_cur_nxt} = sat_add(read_cur_nxt, len_w);
      end
      if (ref_cur_nxt > query_hold_nxt) begin
        flags_nxt.answer_fixed = 1'b1;
        if (mv.is_match) begin
          {ovf_cross, answer_hold_nxt} =
            extrapolate(query_hold_nxt, prior_ref_nxt, prior_read_nxt);
        end else begin
          answer_hold_nxt = prior_read_nxt;
        end
      end else begin
        prior_ref_nxt  = ref_cur_nxt;
        prior_read_nxt = read_cur_nxt;
      end
    end

    // query past the end: extrapolate from the final position
    if (last_op && !flags_nxt.answer_fixed) begin
      {ovf_last, answer_hold_nxt} =
        extrapolate(query_hold_nxt, prior_ref_nxt, prior_read_nxt);
    end

    flags_nxt.overflow_seen = flags_nxt.overflow_seen | ovf_end | ovf_ref |
                              ovf_read | ovf_cross | ovf_last;
  end

  assign res_ref_end     = crm_pkg::POS_W'(end_sum_nxt);
  assign res_read_offset = crm_pkg::POS_W'(answer_hold_nxt);
  assign res_saturated   = flags_nxt.overflow_seen;

endmodule

@@ rtl/cigar_ref_to_read_mapper.sv @@
// ----------------------------------------------------------------------------
// cigar_ref_to_read_mapper
// Translates a queried reference position to a read offset while walking
// one alignment's CIGAR operations, and reports the reference end.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  carries one CIGAR operation per item (length, kind, first/last
//          marks; read start and query position are taken with first_op).
//   out_if carries one result item per record, produced by the operation
//          that has last_op set: reference end, read offset, saturation flag.
//   An accepted operation is captured in the input register, is applied to
//   the record state as it leaves it, and its result lands in the output
//   register. Throughput is one operation per cycle while no last operation
//   waits on the receiver; the running reference offset that the next
//   operation needs is updated as each operation leaves the input register.
//   Operations without last_op never wait for the receiver. When the
//   receiver stalls with a result pending, a last operation holds in the
//   input register and in_if.ready drops until the result is taken.
//   Reset (rst_n low, synchronous) empties both registers and clears the
//   record state, so operations that arrive before any first_op act as a
//   record with start 0 and query 0.
//   POSITION_BITS sets the saturation limit 2^POSITION_BITS - 1 of all sums.
// ----------------------------------------------------------------------------
module cigar_ref_to_read_mapper #(
  parameter int POSITION_BITS = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  crm_in_if.sink      in_if,
  crm_out_if.source   out_if
);

  // input register
  logic                        in_v_r;
  logic [crm_pkg::LEN_W-1:0]   len_r;
  logic [crm_pkg::KIND_W-1:0]  kind_r;
  logic                        first_r;
  logic                        last_r;
  logic [crm_pkg::POS_W-1:0]   start_r;
  logic [crm_pkg::POS_W-1:0]   query_r;

  // record state
  logic [POSITION_BITS-1:0] ref_cur_r,     ref_cur_nxt;
  logic [POSITION_BITS-1:0] read_cur_r,    read_cur_nxt;
  logic [POSITION_BITS-1:0] prior_ref_r,   prior_ref_nxt;
  logic [POSITION_BITS-1:0] prior_read_r,  prior_read_nxt;
  logic [POSITION_BITS-1:0] end_sum_r,     end_sum_nxt;
  logic [POSITION_BITS-1:0] query_hold_r,  query_hold_nxt;
  logic [POSITION_BITS-1:0] answer_hold_r, answer_hold_nxt;
  crm_pkg::crm_flags_t      flags_r,       flags_nxt;

  // output register
  logic                      out_v_r;
  logic [crm_pkg::POS_W-1:0] ref_end_r;
  logic [crm_pkg::POS_W-1:0] read_offset_r;
  logic                      saturated_r;

  logic [crm_pkg::POS_W-1:0] res_ref_end;
  logic [crm_pkg::POS_W-1:0] res_read_offset;
  logic                      res_saturated;
  logic                      advance;

  // Move the held item on unless it carries a result that cannot be placed
  assign advance     = in_v_r && (!last_r || !out_v_r || out_if.ready);
  assign in_if.ready = !in_v_r || advance;

  // Capture accepted items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_if.ready) begin
      in_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      len_r   <= in_if.op_length;
      kind_r  <= in_if.op_kind;
      first_r <= in_if.first_op;
      last_r  <= in_if.last_op;
      start_r <= in_if.read_start;
      query_r <= in_if.query_pos;
    end
  end

  crm_step #(
    .POS_BITS (POSITION_BITS)
  ) u_step (
    .op_length       (len_r),
    .op_kind         (kind_r),
    .first_op        (first_r),
    .last_op         (last_r),
    .read_start      (start_r),
    .query_pos       (query_r),
    .ref_cur         (ref_cur_r),
    .read_cur        (read_cur_r),
    .prior_ref       (prior_ref_r),
    .prior_read      (prior_read_r),
    .end_sum         (end_sum_r),
    .query_hold      (query_hold_r),
    .answer_hold     (answer_hold_r),
    .flags           (flags_r),
    .ref_cur_nxt     (ref_cur_nxt),
    .read_cur_nxt    (read_cur_nxt),
    .prior_ref_nxt   (prior_ref_nxt),
    .prior_read_nxt  (prior_read_nxt),
    .end_sum_nxt     (end_sum_nxt),
    .query_hold_nxt  (query_hold_nxt),
    .answer_hold_nxt (answer_hold_nxt),
    .flags_nxt       (flags_nxt),
    .res_ref_end     (res_ref_end),
    .res_read_offset (res_read_offset),
    .res_saturated   (res_saturated)
  );

  // Commit the record state as each item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_cur_r     <= '0;
      read_cur_r    <= '0;
      prior_ref_r   <= '0;
      prior_read_r  <= '0;
      end_sum_r     <= '0;
      query_hold_r  <= '0;
      answer_hold_r <= '0;
      flags_r       <= '0;
    end else if (advance) begin
      ref_cur_r     <= ref_cur_nxt;
      read_cur_r    <= read_cur_nxt;
      prior_ref_r   <= prior_ref_nxt;
      prior_read_r  <= prior_read_nxt;
      end_sum_r     <= end_sum_nxt;
      query_hold_r  <= query_hold_nxt;
      answer_hold_r <= answer_hold_nxt;
      flags_r       <= flags_nxt;
    end
  end

  // Load a result on the last operation, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && last_r) begin
      out_v_r <= 1'b1;
    end else if (out_if.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_r) begin
      ref_end_r     <= res_ref_end;
      read_offset_r <= res_read_offset;
      saturated_r   <= res_saturated;
    end
  end

  assign out_if.valid       = out_v_r;
  assign out_if.ref_end     = ref_end_r;
  assign out_if.read_offset = read_offset_r;
  assign out_if.saturated   = saturated_r;

  // An open answer means the reference cursor has not passed the query
  a_cursor_before_query: assert property (
    @(posedge clk) disable iff (!rst_n)
    !flags_r.answer_fixed |-> (ref_cur_r <= query_hold_r)
  ) else $error("reference cursor past query while answer still open");

  // An operation without last mark never creates or removes a result
  a_no_result_from_middle: assert property (
    @(posedge clk) disable iff (!rst_n)
    (advance && !last_r) |=> (out_v_r == $past(out_v_r && !out_if.ready))
  ) else $error("result appeared or vanished on a non-last operation");

  // An empty input register always takes an item
  a_empty_takes_item: assert property (
    @(posedge clk) disable iff (!rst_n)
    !in_v_r |-> in_if.ready
  ) else $error("input register empty but not ready");

endmodule
